>>> hw/rtl/longest_palindrome_finder_macros.svh
// Assertion macros of the palindrome finder RTL.
`ifndef LONGEST_PALINDROME_FINDER_MACROS_SVH
`define LONGEST_PALINDROME_FINDER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define LPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lpf_pkg.sv
// Types and constants of the longest palindrome finder.
`default_nettype none

package lpf_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int CTR_W   = CNT_W + 1;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] best_start;
      logic [CNT_W-1:0]  best_length;
      logic              overflowed;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } mem_req_type;

endpackage

`default_nettype wire

>>> hw/rtl/lpf_char_mem.sv
// Character store: one write port, two registered read ports.
`default_nettype none

module lpf_char_mem (
   input  wire logic                    clock,
   input  wire lpf_pkg::mem_req_type    mem_req,
   output logic [7:0]                   rd_a,
   output logic [7:0]                   rd_b
);

   logic [7:0] mem [lpf_pkg::MAX_LEN];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_a <= mem[mem_req.raddr_a];
         rd_b <= mem[mem_req.raddr_b];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/longest_palindrome_finder.sv
// Top level of the longest palindrome finder: load, center sweep and result.
//
// Usage: send a string one byte per request. A request is taken on a rising
// edge with start high and busy low; req_item carries the byte and is_last.
// Bytes load at one per cycle while busy is low into a 1024-entry store;
// bytes beyond that are dropped and the overflow flag is set. The request
// with is_last high (stored or dropped) starts the search and raises busy.
// The search walks every center (2n-1 of them for n stored bytes) and grows
// each outward with one exact byte compare through the two read ports of the
// store. Each center takes a setup step, then a read and a compare for each
// matching pair, and ends with a read that stops at the string edge, or a
// compare that finds a mismatch, followed by an update of the best run.
// The result (start, length, overflow) shows on rsp_item for exactly one
// cycle with rsp_valid high; the receiver cannot stall it. busy drops in that
// same cycle, and the next string may start at once.
// Reset (synchronous, active high) clears the byte count, the overflow flag
// and the sequencer; the store contents are not cleared.
`default_nettype none
`include "longest_palindrome_finder_macros.svh"

module longest_palindrome_finder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lpf_pkg::req_type req_item,
   output logic                  rsp_valid,
   output lpf_pkg::rsp_type      rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_CMP,
      ST_UPDATE
   } state_type;

   state_type                    state_ff;
   logic [lpf_pkg::CNT_W-1:0]    count_ff;
   logic                         ovf_ff;
   logic [lpf_pkg::CTR_W-1:0]    ctr_ff;
   logic [lpf_pkg::CNT_W-1:0]    lptr_ff;
   logic [lpf_pkg::CNT_W-1:0]    rptr_ff;
   logic [lpf_pkg::ADDR_W-1:0]   bstart_ff;
   logic [lpf_pkg::CNT_W-1:0]    blen_ff;
   logic                         rsp_valid_ff;
   lpf_pkg::rsp_type             rsp_ff;

   lpf_pkg::mem_req_type         mem_req;
   logic [7:0]                   rd_a;
   logic [7:0]                   rd_b;

   logic                         accept;
   logic                         full;
   logic                         in_bounds;
   logic [lpf_pkg::CTR_W-1:0]    last_ctr;
   logic [lpf_pkg::CNT_W-1:0]    cand_len;
   logic [lpf_pkg::CNT_W-1:0]    cand_start_w;
   logic [lpf_pkg::ADDR_W-1:0]   cand_start;
   logic                         take;
   logic [lpf_pkg::ADDR_W-1:0]   bstart_in;
   logic [lpf_pkg::CNT_W-1:0]    blen_in;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == lpf_pkg::CNT_W'(lpf_pkg::MAX_LEN));

   // Left pointer wraps past zero into the top bit; right stops at the count.
   assign in_bounds = !lptr_ff[lpf_pkg::CNT_W-1] && (rptr_ff < count_ff);

   // Centers run 0 .. 2n-2: even ones sit on a byte, odd ones between two.
   assign last_ctr = {count_ff, 1'b0} - lpf_pkg::CTR_W'(2);

   // Matched run lies strictly between the pointers.
   assign cand_len     = rptr_ff - lptr_ff - lpf_pkg::CNT_W'(1);
   assign cand_start_w = lptr_ff + lpf_pkg::CNT_W'(1);
   assign cand_start   = cand_start_w[lpf_pkg::ADDR_W-1:0];
   assign take = (cand_len > blen_ff) ||
                 ((cand_len == blen_ff) && (cand_start < bstart_ff));
   assign bstart_in = take ? cand_start : bstart_ff;
   assign blen_in   = take ? cand_len : blen_ff;

   always_comb begin
      mem_req.we      = accept && !full;
      mem_req.waddr   = count_ff[lpf_pkg::ADDR_W-1:0];
      mem_req.wdata   = req_item.char_byte;
      mem_req.re      = (state_ff == ST_READ) && in_bounds;
      mem_req.raddr_a = lptr_ff[lpf_pkg::ADDR_W-1:0];
      mem_req.raddr_b = rptr_ff[lpf_pkg::ADDR_W-1:0];
   end

   lpf_char_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // Store the byte, or drop it and flag the overflow.
                  if (full) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + lpf_pkg::CNT_W'(1);
                  end
                  if (req_item.is_last) begin
                     ctr_ff    <= '0;
                     bstart_ff <= '0;
                     blen_ff   <= lpf_pkg::CNT_W'(1);
                     state_ff  <= ST_SETUP;
                  end
               end
            end
            ST_SETUP: begin
               // Seed the inner pair of the current center.
               lptr_ff  <= ctr_ff[lpf_pkg::CTR_W-1:1];
               rptr_ff  <= ctr_ff[lpf_pkg::CTR_W-1:1] +
                           lpf_pkg::CNT_W'(ctr_ff[0]);
               state_ff <= ST_READ;
            end
            ST_READ: begin
               // Fetch both ends, or stop growing at the string edge.
               state_ff <= in_bounds ? ST_CMP : ST_UPDATE;
            end
            ST_CMP: begin
               if (rd_a == rd_b) begin
                  lptr_ff  <= lptr_ff - lpf_pkg::CNT_W'(1);
                  rptr_ff  <= rptr_ff + lpf_pkg::CNT_W'(1);
                  state_ff <= ST_READ;
               end else begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               bstart_ff <= bstart_in;
               blen_ff   <= blen_in;
               if (ctr_ff == last_ctr) begin
                  // Emit the result and clear for the next string.
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.best_start   <= bstart_in;
                  rsp_ff.best_length  <= blen_in;
                  rsp_ff.overflowed   <= ovf_ff;
                  count_ff            <= '0;
                  ovf_ff              <= 1'b0;
                  state_ff            <= ST_IDLE;
               end else begin
                  ctr_ff   <= ctr_ff + lpf_pkg::CTR_W'(1);
                  state_ff <= ST_SETUP;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `LPF_ASSERT(a_count_bound, clock, reset,
      count_ff <= lpf_pkg::CNT_W'(lpf_pkg::MAX_LEN), "byte count above store size")
   `LPF_ASSERT(a_cmp_in_bounds, clock, reset,
      (state_ff == ST_CMP) |-> in_bounds, "compare outside stored string")
   `LPF_ASSERT_NEXT(a_last_starts, clock, reset,
      accept && req_item.is_last, busy, "last byte did not start search")
   `LPF_ASSERT_NEXT(a_single_rsp, clock, reset,
      rsp_valid_ff, !rsp_valid_ff, "result repeated")
   `LPF_ASSERT(a_rsp_len, clock, reset,
      rsp_valid_ff |-> (rsp_ff.best_length != '0), "empty palindrome reported")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the longest palindrome finder: directed table, random strings.

module tb;

   // Hard stop for a hung run; a normal run ends well inside this.
   localparam int RUN_LIMIT_NS = 12_000_000;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASE_COUNT  = 4;

   typedef logic [7:0] text_type[$];

   // One row of the directed table: the request, and the result typed in by hand
   // when the row closes a string.
   typedef struct packed {
      lpf_pkg::req_type req;
      logic             typed;
      lpf_pkg::rsp_type want;
   } drill_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   lpf_pkg::req_type req_item;
   logic             rsp_valid;
   lpf_pkg::rsp_type rsp_item;

   // Mirror of the block's state: bytes of the current string, count, overflow.
   logic [7:0] held_bytes [lpf_pkg::MAX_LEN];
   int         held_count;
   logic       held_ovf;

   lpf_pkg::rsp_type pending_results[$];
   int               mismatch_count;

   // Strings with hand-worked answers: lone bytes at both extremes, no match,
   // a two-byte run, an even run off index 0, a tie between two odd runs
   // (earliest start must win), and runs built from extreme byte values.
   drill_row_type drill_table [0:24] = '{
      '{'{8'h00, 1'b1}, 1'b1, '{10'd0, 11'd1, 1'b0}},
      '{'{8'hFF, 1'b1}, 1'b1, '{10'd0, 11'd1, 1'b0}},
      '{'{8'h61, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b1}, 1'b1, '{10'd0, 11'd1, 1'b0}},
      '{'{8'h61, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b1}, 1'b1, '{10'd0, 11'd2, 1'b0}},
      '{'{8'h78, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b1}, 1'b1, '{10'd1, 11'd4, 1'b0}},
      '{'{8'h61, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b0}, 1'b0, '0},
      '{'{8'h63, 1'b0}, 1'b0, '0},
      '{'{8'h64, 1'b0}, 1'b0, '0},
      '{'{8'h63, 1'b1}, 1'b1, '{10'd0, 11'd3, 1'b0}},
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1}, 1'b1, '{10'd0, 11'd3, 1'b0}},
      '{'{8'h80, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b0}, 1'b0, '0},
      '{'{8'h01, 1'b1}, 1'b1, '{10'd0, 11'd4, 1'b0}}
   };

   int idle_pcts [PHASE_COUNT] = '{0, 65, 31, 0};

   longest_palindrome_finder dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // 12 ns clock, first rising edge at 6 ns.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Count matching pairs while growing outward from the inner pair lo, hi.
   function automatic int matched_pairs(input int lo, input int hi, input int n);
      int k;
      k = 0;
      while (lo - k >= 0 && hi + k < n && held_bytes[lo - k] == held_bytes[hi + k])
         k++;
      return k;
   endfunction

   // Sweep every odd and even center of the held string; keep the longest run,
   // and on a tie keep the one that starts first.
   function automatic lpf_pkg::rsp_type longest_palindrome();
      lpf_pkg::rsp_type res;
      int               best_s;
      int               best_l;
      int               k;
      int               s;
      int               l;
      best_s = 0;
      best_l = 1;
      for (int i = 0; i < held_count; i++) begin
         k = matched_pairs(i, i, held_count);
         l = 2 * k - 1;
         s = i + 1 - k;
         if (l > best_l || (l == best_l && s < best_s)) begin
            best_l = l;
            best_s = s;
         end
         if (i + 1 < held_count) begin
            k = matched_pairs(i, i + 1, held_count);
            if (k > 0) begin
               l = 2 * k;
               s = i + 1 - k;
               if (l > best_l || (l == best_l && s < best_s)) begin
                  best_l = l;
                  best_s = s;
               end
            end
         end
      end
      res.best_start  = best_s[lpf_pkg::ADDR_W-1:0];
      res.best_length = best_l[lpf_pkg::CNT_W-1:0];
      res.overflowed  = held_ovf;
      return res;
   endfunction

   // Store one accepted byte; drop it and flag overflow once the store is full.
   // Return 1 with the expected result when the byte closes the string.
   function automatic bit take_byte(input lpf_pkg::req_type r,
                                    output lpf_pkg::rsp_type res);
      res = '0;
      if (held_count < lpf_pkg::MAX_LEN) begin
         held_bytes[held_count] = r.char_byte;
         held_count++;
      end else begin
         held_ovf = 1'b1;
      end
      if (!r.is_last)
         return 1'b0;
      res = longest_palindrome();
      held_count = 0;
      held_ovf = 1'b0;
      return 1'b1;
   endfunction

   // Offer one request, after an optional idle gap, and hold it until accepted.
   // Queue the typed result if given, else the predicted one.
   task automatic send_request(input lpf_pkg::req_type r, input int idle_pct,
                               input logic typed, input lpf_pkg::rsp_type want);
      int               gap;
      lpf_pkg::rsp_type predicted;
      gap = 0;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct)
         gap = $urandom_range(4, 1);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (take_byte(r, predicted)) begin
         if (typed)
            predicted = want;
         pending_results = {pending_results, predicted};
      end
   endtask

   task automatic send_string(input text_type text, input int idle_pct);
      lpf_pkg::req_type r;
      for (int i = 0; i < text.size(); i++) begin
         r.char_byte = text[i];
         r.is_last   = (i == text.size() - 1);
         send_request(r, idle_pct, 1'b0, '0);
      end
   endtask

   // Drop start and hold off until every queued result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Mostly strings over a few symbols, so that runs of some length turn up,
   // with mirrored cores planted in random text, single-byte repeats, and some
   // full-range noise. Lengths stay short, with the odd longer one.
   function automatic text_type make_text();
      text_type t;
      text_type mid;
      int       style;
      int       len;
      int       base;
      int       half;
      style = $urandom_range(9);
      len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      base  = $urandom_range(252);
      if (style < 2) begin
         repeat (len) t = {t, 8'($urandom_range(255))};
      end else if (style == 2) begin
         repeat (len) t = {t, 8'(base)};
      end else if (style < 6) begin
         repeat (len) t = {t, 8'(base + $urandom_range(2))};
      end else begin
         half = $urandom_range(6, 1);
         repeat ($urandom_range(3)) t = {t, 8'(base + $urandom_range(3))};
         repeat (half) mid = {mid, 8'(base + $urandom_range(3))};
         t = {t, mid};
         if ($urandom_range(1))
            t = {t, 8'(base + $urandom_range(3))};
         for (int i = half - 1; i >= 0; i--)
            t = {t, mid[i]};
         repeat ($urandom_range(3)) t = {t, 8'(base + $urandom_range(3))};
      end
      return t;
   endfunction

   // Check each result strobe against the oldest expectation, field by field.
   always @(posedge clock) begin : rsp_check
      lpf_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with none pending, best_start",
                            int'(rsp_item.best_start), -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.best_start !== want.best_start)
               report_mismatch("best_start", int'(rsp_item.best_start),
                               int'(want.best_start));
            if (rsp_item.best_length !== want.best_length)
               report_mismatch("best_length", int'(rsp_item.best_length),
                               int'(want.best_length));
            if (rsp_item.overflowed !== want.overflowed)
               report_mismatch("overflowed", int'(rsp_item.overflowed),
                               int'(want.overflowed));
         end
      end
   end

   initial begin : stimulus
      text_type text;
      int       sent;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      held_count     = 0;
      held_ovf       = 1'b0;
      mismatch_count = 0;
      sent           = 0;

      // Hold reset, then release it on an edge.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table back to back.
      foreach (drill_table[i])
         send_request(drill_table[i].req, 0, drill_table[i].typed, drill_table[i].want);
      drain_results();

      // Random strings, one idling pattern per phase; drain between phases so
      // the sender sits idle with nothing in flight at least once.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         while (sent < (p + 1) * RANDOM_ITEMS / PHASE_COUNT) begin
            text = make_text();
            send_string(text, idle_pcts[p]);
            sent += text.size();
         end
         drain_results();
      end

      // Overrun the store: a full-length mirrored run fills it, and three more
      // bytes, the closing one among them, are dropped.
      text.delete();
      repeat (lpf_pkg::MAX_LEN / 2) text = {text, 8'($urandom_range(255))};
      for (int i = lpf_pkg::MAX_LEN / 2 - 1; i >= 0; i--)
         text = {text, text[i]};
      repeat (3) text = {text, 8'($urandom_range(255))};
      send_string(text, 0);
      drain_results();

      // Give a stray result time to show before judging the run.
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #RUN_LIMIT_NS;
      $display("status: fail");
      $finish;
   end

endmodule
